/* rtl/core/ipv4_dotted_quad_parser_defines.svh */
// ----------------------------------------------------------------------------
// IPv4 dotted-quad parser assertion macros
// Shared concurrent assertion forms, clocked on clk, held off during rst.
// ----------------------------------------------------------------------------
`ifndef IPV4_DOTTED_QUAD_PARSER_DEFINES_SVH
`define IPV4_DOTTED_QUAD_PARSER_DEFINES_SVH

// same-cycle implication
`define IPV4DQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ipv4dq assertion failed");

// next-cycle implication
`define IPV4DQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ipv4dq assertion failed");

`endif

/* rtl/core/ipv4dq_pkg.sv */
// ----------------------------------------------------------------------------
// ipv4dq_pkg
// Types and constants shared by the IPv4 dotted-quad parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4dq_pkg;

  localparam logic [7:0] DOT_CODE   = 8'h2E;
  localparam logic [7:0] DIGIT_LO   = 8'h30;  // '0'
  localparam logic [7:0] DIGIT_HI   = 8'h39;  // '9'
  localparam logic [7:0] MIN_LEN    = 8'd7;
  localparam logic [7:0] MAX_LEN_IN = 8'd15;
  localparam logic [3:0] MAX_LEN    = 4'd15;
  localparam logic [1:0] LAST_GROUP = 2'd3;
  localparam logic [1:0] DIGITS_MAX = 2'd3;
  localparam logic [9:0] OCTET_MAX  = 10'd255;

  typedef enum logic [1:0] {
    ERR_OK      = 2'd0,
    ERR_SHORT   = 2'd1,
    ERR_INVALID = 2'd2,
    ERR_RANGE   = 2'd3
  } err_t;

  typedef struct packed {
    logic        busy;
    logic [1:0]  group_number;
    logic [1:0]  digit_count;
    logic [9:0]  octet_acc;
    logic [31:0] address_shift;
    logic [3:0]  char_count;
    logic [3:0]  length_limit;
    logic        expect_dot;
  } parse_state_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] address;
    err_t        error;
    logic [3:0]  count;
  } step_result_t;

endpackage

`default_nettype wire

/* rtl/core/ipv4_dotted_quad_parser.sv */
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_parser
// Dotted-decimal IPv4 text in, one character per transfer; one result per
// finished text out (address, error code, characters consumed).
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------
//  in      | in_valid / in_ready  | char_code, first_char, declared_length
//  out     | out_valid / out_ready| address, error_code, consumed_count
//
//  Rate: one character per cycle, sustained while out_ready is high.
//  Path: a character is held in the input register; when it advances, the
//  step logic loads the result register from it, so out_valid rises once
//  the character that ends the text has passed both registers.
//  Reset (rst, synchronous): parser waits for a first character, limit 15,
//  no result pending.
//  Stalls: the input register holds while a result waits on out_ready;
//  in_ready drops only when the input register is full and that result waits.
//
`default_nettype none

module ipv4_dotted_quad_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        first_char,
  input  logic [7:0]  declared_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] address,
  output logic [1:0]  error_code,
  output logic [3:0]  consumed_count
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_first;
  logic [7:0] s1_len;

  // parse state
  ipv4dq_pkg::parse_state_t state;
  ipv4dq_pkg::parse_state_t state_next;
  ipv4dq_pkg::step_result_t step_res;

  logic advance;

  // the staged character moves on whenever the result register has room
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_char  <= char_code;
      s1_first <= first_char;
      s1_len   <= declared_length;
    end
  end

  ipv4dq_step u_step (
    .cur             (state),
    .char_code       (s1_char),
    .first_char      (s1_first),
    .declared_length (s1_len),
    .nxt             (state_next),
    .res             (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.busy          <= 1'b0;
      state.group_number  <= 2'd0;
      state.digit_count   <= 2'd0;
      state.octet_acc     <= 10'd0;
      state.address_shift <= 32'd0;
      state.char_count    <= 4'd0;
      state.length_limit  <= ipv4dq_pkg::MAX_LEN;
      state.expect_dot    <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register: loaded when a text finishes, else cleared on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && step_res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_res.valid) begin
      address        <= step_res.address;
      error_code     <= step_res.error;
      consumed_count <= step_res.count;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ipv4dq_step.sv */
// ----------------------------------------------------------------------------
// ipv4dq_step
// One character of parsing: next parse state and the result it may raise.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4dq_step (
  input  ipv4dq_pkg::parse_state_t cur,
  input  logic [7:0]               char_code,
  input  logic                     first_char,
  input  logic [7:0]               declared_length,
  output ipv4dq_pkg::parse_state_t nxt,
  output ipv4dq_pkg::step_result_t res
);

  ipv4dq_pkg::parse_state_t s;
  ipv4dq_pkg::err_t         err;
  logic                     fin;
  logic                     is_digit;
  logic                     is_dot;
  logic                     short_len;
  logic [9:0]               acc_new;
  logic [1:0]               dc_new;

  always_comb begin
    s         = cur;
    fin       = 1'b0;
    err       = ipv4dq_pkg::ERR_OK;
    is_digit  = char_code inside {[ipv4dq_pkg::DIGIT_LO : ipv4dq_pkg::DIGIT_HI]};
    is_dot    = (char_code == ipv4dq_pkg::DOT_CODE);
    short_len = first_char && (declared_length != 8'd0) &&
                (declared_length < ipv4dq_pkg::MIN_LEN);

    if (first_char) begin
      s.group_number  = 2'd0;
      s.digit_count   = 2'd0;
      s.octet_acc     = 10'd0;
      s.address_shift = 32'd0;
      s.char_count    = 4'd0;
      s.expect_dot    = 1'b0;
    end

    // acc * 10 + digit, from the state after any restart; acc is at most 99 here
    acc_new   = {s.octet_acc[6:0], 3'b000} + {s.octet_acc[8:0], 1'b0} +
                {6'd0, char_code[3:0]};
    dc_new    = s.digit_count + 2'd1;

    if (short_len) begin
      s.length_limit = ipv4dq_pkg::MAX_LEN;
      fin = 1'b1;
      err = ipv4dq_pkg::ERR_SHORT;
    end else begin
      if (first_char) begin
        s.length_limit = ((declared_length == 8'd0) ||
                          (declared_length > ipv4dq_pkg::MAX_LEN_IN)) ?
                         ipv4dq_pkg::MAX_LEN : declared_length[3:0];
        s.busy = 1'b1;
      end
      if (s.busy) begin
        if (s.expect_dot) begin
          if (!is_dot) begin
            fin = 1'b1;
            err = ipv4dq_pkg::ERR_INVALID;
          end else begin
            s.char_count   = s.char_count + 4'd1;
            s.group_number = s.group_number + 2'd1;
            s.digit_count  = 2'd0;
            s.octet_acc    = 10'd0;
            s.expect_dot   = 1'b0;
            if (s.char_count >= s.length_limit) begin
              fin = 1'b1;
              err = ipv4dq_pkg::ERR_SHORT;
            end
          end
        end else if (is_digit) begin
          s.octet_acc   = acc_new;
          s.char_count  = s.char_count + 4'd1;
          s.digit_count = dc_new;
          if (dc_new == ipv4dq_pkg::DIGITS_MAX) begin
            if (acc_new > ipv4dq_pkg::OCTET_MAX) begin
              fin = 1'b1;
              err = ipv4dq_pkg::ERR_RANGE;
            end else begin
              case (s.group_number)
                2'd0:    s.address_shift[31:24] = acc_new[7:0];
                2'd1:    s.address_shift[23:16] = acc_new[7:0];
                2'd2:    s.address_shift[15:8]  = acc_new[7:0];
                default: s.address_shift[7:0]   = acc_new[7:0];
              endcase
              if (s.group_number == ipv4dq_pkg::LAST_GROUP) begin
                fin = 1'b1;
                err = ipv4dq_pkg::ERR_OK;
              end else begin
                s.expect_dot = 1'b1;
                if (s.char_count >= s.length_limit) begin
                  fin = 1'b1;
                  err = ipv4dq_pkg::ERR_SHORT;
                end
              end
            end
          end else if (s.char_count >= s.length_limit) begin
            fin = 1'b1;
            if (s.group_number == ipv4dq_pkg::LAST_GROUP) begin
              s.address_shift[7:0] = acc_new[7:0];
              err = ipv4dq_pkg::ERR_OK;
            end else begin
              err = ipv4dq_pkg::ERR_SHORT;
            end
          end
        end else begin
          if (s.digit_count == 2'd0) begin
            fin = 1'b1;
            err = ipv4dq_pkg::ERR_INVALID;
          end else begin
            case (s.group_number)
              2'd0:    s.address_shift[31:24] = s.octet_acc[7:0];
              2'd1:    s.address_shift[23:16] = s.octet_acc[7:0];
              2'd2:    s.address_shift[15:8]  = s.octet_acc[7:0];
              default: s.address_shift[7:0]   = s.octet_acc[7:0];
            endcase
            if (s.group_number == ipv4dq_pkg::LAST_GROUP) begin
              fin = 1'b1;
              err = ipv4dq_pkg::ERR_OK;
            end else if (!is_dot) begin
              fin = 1'b1;
              err = ipv4dq_pkg::ERR_INVALID;
            end else begin
              s.char_count   = s.char_count + 4'd1;
              s.group_number = s.group_number + 2'd1;
              s.digit_count  = 2'd0;
              s.octet_acc    = 10'd0;
              s.expect_dot   = 1'b0;
              if (s.char_count >= s.length_limit) begin
                fin = 1'b1;
                err = ipv4dq_pkg::ERR_SHORT;
              end
            end
          end
        end
      end
    end

    if (fin) begin
      s.busy = 1'b0;
    end
    nxt         = s;
    res.valid   = fin;
    res.address = s.address_shift;
    res.error   = err;
    res.count   = s.char_count;
  end

endmodule

`default_nettype wire

/* rtl/core/ipv4dq_checker.sv */
// ----------------------------------------------------------------------------
// ipv4dq_checker
// Port-level checks on the IPv4 dotted-quad parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ipv4_dotted_quad_parser_defines.svh"

module ipv4dq_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  char_code,
  input logic        first_char,
  input logic [7:0]  declared_length,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] address,
  input logic [1:0]  error_code,
  input logic [3:0]  consumed_count
);

  // stalled result holds
  `IPV4DQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(address) && $stable(error_code) && $stable(consumed_count))

  // back-pressure only ever comes from a stalled result
  `IPV4DQ_ASSERT_NOW(a_ready_cause, !in_ready, out_valid && !out_ready)

  // success needs four groups and three dots
  `IPV4DQ_ASSERT_NOW(a_ok_count, out_valid && (error_code == ipv4dq_pkg::ERR_OK), consumed_count >= 4'd7)

  // a large octet is only flagged on its third digit
  `IPV4DQ_ASSERT_NOW(a_range_count, out_valid && (error_code == ipv4dq_pkg::ERR_RANGE), consumed_count >= 4'd3)

endmodule

bind ipv4_dotted_quad_parser ipv4dq_checker u_checker (.*);

`default_nettype wire

/* verif/ipv4_dotted_quad_parser_check.sv */
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_parser_check
// Watches both channels of the parser, predicts each result from the input
// transfers and compares every output transfer with the oldest prediction.
// ----------------------------------------------------------------------------

module ipv4_dotted_quad_parser_check
  import ipv4dq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        first_char,
  input  logic [7:0]  declared_length,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] address,
  input  logic [1:0]  error_code,
  input  logic [3:0]  consumed_count,
  output int unsigned mismatch_count,
  output int unsigned pending_count
);

  typedef struct {
    logic [31:0] address;
    err_t        error;
    logic [3:0]  count;
  } parse_outcome_t;

  parse_state_t   parser;
  parse_outcome_t awaited_q[$];

  task automatic report_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] wanted);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, seen, wanted, $realtime);
    mismatch_count += 1;
  endtask

  function automatic void clear_text();
    parser.group_number  = '0;
    parser.digit_count   = '0;
    parser.octet_acc     = '0;
    parser.address_shift = '0;
    parser.char_count    = '0;
    parser.expect_dot    = 1'b0;
  endfunction

  function automatic bit close_text(input err_t err, output parse_outcome_t res);
    res.address = parser.address_shift;
    res.error   = err;
    res.count   = parser.char_count;
    parser.busy = 1'b0;
    return 1'b1;
  endfunction

  function automatic void store_octet();
    parser.address_shift |= {24'd0, parser.octet_acc[7:0]}
                            << (8 * (LAST_GROUP - parser.group_number));
  endfunction

  function automatic void open_following_group();
    parser.group_number = parser.group_number + 2'd1;
    parser.digit_count  = '0;
    parser.octet_acc    = '0;
    parser.expect_dot   = 1'b0;
  endfunction

  // one character in; returns 1 when it closes the text
  function automatic bit parse_char(input logic [7:0] c, input logic first,
                                    input logic [7:0] dl, output parse_outcome_t res);
    res = '{address: '0, error: ERR_OK, count: '0};
    if (first) begin
      clear_text();
      if (dl != 8'd0 && dl < MIN_LEN) begin
        parser.length_limit = MAX_LEN;
        return close_text(ERR_SHORT, res);
      end
      parser.length_limit = (dl == 8'd0 || dl > MAX_LEN_IN) ? MAX_LEN : dl[3:0];
      parser.busy = 1'b1;
    end
    if (!parser.busy)
      return 1'b0;

    if (parser.expect_dot) begin
      if (c != DOT_CODE)
        return close_text(ERR_INVALID, res);
      parser.char_count += 4'd1;
      open_following_group();
      if (parser.char_count >= parser.length_limit)
        return close_text(ERR_SHORT, res);
      return 1'b0;
    end

    if (c >= DIGIT_LO && c <= DIGIT_HI) begin
      parser.octet_acc    = 10'(parser.octet_acc * 10 + (c - DIGIT_LO));
      parser.char_count  += 4'd1;
      parser.digit_count += 2'd1;
      if (parser.digit_count == DIGITS_MAX) begin
        if (parser.octet_acc > OCTET_MAX)
          return close_text(ERR_RANGE, res);
        store_octet();
        if (parser.group_number == LAST_GROUP)
          return close_text(ERR_OK, res);
        parser.expect_dot = 1'b1;
        if (parser.char_count >= parser.length_limit)
          return close_text(ERR_SHORT, res);
        return 1'b0;
      end
      if (parser.char_count >= parser.length_limit) begin
        if (parser.group_number == LAST_GROUP) begin
          store_octet();
          return close_text(ERR_OK, res);
        end
        return close_text(ERR_SHORT, res);
      end
      return 1'b0;
    end

    // non-digit
    if (parser.digit_count == 2'd0)
      return close_text(ERR_INVALID, res);
    store_octet();
    if (parser.group_number == LAST_GROUP)
      return close_text(ERR_OK, res);
    if (c != DOT_CODE)
      return close_text(ERR_INVALID, res);
    parser.char_count += 4'd1;
    open_following_group();
    if (parser.char_count >= parser.length_limit)
      return close_text(ERR_SHORT, res);
    return 1'b0;
  endfunction

  always @(posedge clk) begin : watch
    parse_outcome_t want;
    parse_outcome_t fresh;
    if (rst) begin
      parser              = '0;
      parser.length_limit = MAX_LEN;
      awaited_q.delete();
      mismatch_count      = 0;
    end else begin
      // output first: a result never belongs to the character of this edge
      if (out_valid && out_ready) begin
        if (awaited_q.size() == 0) begin
          report_mismatch("result with none awaited", address, '0);
        end else begin
          want = awaited_q.pop_front();
          if (address !== want.address)
            report_mismatch("address", address, want.address);
          if (error_code !== want.error)
            report_mismatch("error_code", {30'd0, error_code}, {30'd0, want.error});
          if (consumed_count !== want.count)
            report_mismatch("consumed_count", {28'd0, consumed_count}, {28'd0, want.count});
        end
      end
      if (in_valid && in_ready) begin
        if (parse_char(char_code, first_char, declared_length, fresh))
          awaited_q.push_back(fresh);
      end
    end
    pending_count <= awaited_q.size();
  end

endmodule

/* verif/ipv4_dotted_quad_parser_test.sv */
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_parser_test
// Drives address text into the parser, character by character, with random
// gaps and output stalls; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------

module ipv4_dotted_quad_parser_test;
  import ipv4dq_pkg::*;

  typedef byte unsigned text_t[$];

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  char_code;
  logic        first_char;
  logic [7:0]  declared_length;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] address;
  logic [1:0]  error_code;
  logic [3:0]  consumed_count;

  int unsigned mismatch_count;
  int unsigned pending_count;

  // idling controls: gaps on the input, stalls on the output, and a calm
  // final stretch where neither side idles
  bit          feed_gaps;
  bit          drain_stalls;
  bit          settle;
  int unsigned stall_left;
  int unsigned chars_sent;

  ipv4_dotted_quad_parser dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .char_code       (char_code),
    .first_char      (first_char),
    .declared_length (declared_length),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .address         (address),
    .error_code      (error_code),
    .consumed_count  (consumed_count)
  );

  ipv4_dotted_quad_parser_check checker_i (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .char_code       (char_code),
    .first_char      (first_char),
    .declared_length (declared_length),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .address         (address),
    .error_code      (error_code),
    .consumed_count  (consumed_count),
    .mismatch_count  (mismatch_count),
    .pending_count   (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop, well beyond the slowest legal run
  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

  // Output side: occasional stall bursts, switched off in calm
  // stretches and for the tail of the run.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (drain_stalls && !settle && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_ready  <= 1'b0;
    end else begin
      out_ready  <= 1'b1;
    end
  end

  // One character transfer. An optional gap comes first; valid then stays
  // high with the payload held until in_ready is seen at an edge. The next
  // call drives the new payload at the very edge of the transfer, so valid
  // is never dropped and raised in one step.
  task automatic send_char(input logic [7:0] c, input logic first, input logic [7:0] dl);
    if (feed_gaps && !settle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    char_code       <= c;
    first_char      <= first;
    declared_length <= dl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent += 1;
  endtask

  // whole text: the first character carries the declared length, the rest
  // carry junk in that field since it is only read with first_char
  task automatic send_text(input text_t txt, input logic [7:0] dl);
    logic [7:0] junk;
    for (int i = 0; i < txt.size(); i++) begin
      junk = 8'($urandom_range(0, 255));
      send_char(txt[i], i == 0, (i == 0) ? dl : junk);
    end
  endtask

  task automatic send_string(input string s, input logic [7:0] dl);
    text_t txt;
    for (int i = 0; i < s.len(); i++)
      txt.push_back(s[i]);
    send_text(txt, dl);
  endtask

  initial begin
    text_t       txt;
    int unsigned ndig;
    int unsigned addr_len;
    int unsigned random_end;
    logic [7:0]  dl;
    logic [7:0]  noise_dl;

    rst             <= 1'b1;
    in_valid        <= 1'b0;
    char_code       <= '0;
    first_char      <= 1'b0;
    declared_length <= '0;
    feed_gaps    = 1'b0;
    drain_stalls = 1'b0;
    settle       = 1'b0;
    chars_sent   = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // --- directed ------------------------------------------------------
    send_char("5", 1'b1, 8'd3);        // short declared length: instant error
    send_char("7", 1'b0, 8'hFF);       // idle character, ignored
    send_string("1.", 8'd0);           // dropped by the restart below
    send_string("0.0.0.0", MIN_LEN);   // exactly fitting length succeeds
    send_string("256", 8'd0);          // octet above 255 on its third digit
    send_string(".", 8'd0);            // empty group
    send_string("1a", 8'd0);           // group ended by a non-dot
    send_string("123x", 8'd0);         // no dot after three digits
    send_string("12.34.5", MIN_LEN);   // limit reached before fourth group
    send_string("9.8.7.6/", 8'hFF);    // fourth group ended by a non-digit

    // --- random --------------------------------------------------------
    random_end = chars_sent + 1950;
    while (chars_sent < random_end) begin
      feed_gaps    = ($urandom_range(0, 2) != 0);
      drain_stalls = ($urandom_range(0, 2) != 0);
      settle       = (chars_sent + 300 > random_end);
      txt = {};
      if ($urandom_range(0, 19) < 3) begin
        // noise: stray bytes with random first marks
        repeat ($urandom_range(1, 6)) begin
          noise_dl = 8'($urandom_range(0, 255));
          send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), noise_dl);
        end
      end else begin
        // dotted quad, leading zeros allowed; a three-digit octet may go above 255
        for (int g = 0; g < 4; g++) begin
          ndig = $urandom_range(1, 3);
          for (int k = 0; k < ndig; k++) begin
            if (ndig == 3 && k == 0)
              txt.push_back(DIGIT_LO + 8'($urandom_range(0, 2)));
            else
              txt.push_back(DIGIT_LO + 8'($urandom_range(0, 9)));
          end
          if (g != 3)
            txt.push_back(DOT_CODE);
        end
        addr_len = txt.size();
        if ($urandom_range(0, 1) == 0)
          txt.push_back(8'($urandom_range(0, 255)));   // terminator, any byte
        case ($urandom_range(0, 7))
          0:       dl = 8'd0;
          1, 2:    dl = 8'(addr_len);
          3:       dl = 8'($urandom_range(7, 15));
          4:       dl = 8'($urandom_range(16, 255));
          5:       dl = 8'($urandom_range(1, 6));
          6:       dl = 8'($urandom_range(7, addr_len));
          default: dl = 8'($urandom_range(0, 255));
        endcase
        // a quarter broken: one byte replaced, or the tail cut off
        case ($urandom_range(0, 7))
          0:       txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
          1:       repeat ($urandom_range(1, txt.size() - 1)) void'(txt.pop_back());
          default: ;
        endcase
        send_text(txt, dl);
      end
    end
    in_valid <= 1'b0;

    // drain: wait for every predicted result, then let any late result show up
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/ipv4dq_pkg.sv
rtl/core/ipv4dq_step.sv
rtl/core/ipv4_dotted_quad_parser.sv
rtl/core/ipv4dq_checker.sv
verif/ipv4_dotted_quad_parser_check.sv
verif/ipv4_dotted_quad_parser_test.sv
